// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rotation to euler angle core
// no dependencies, clock and reset names follow the core port names
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define R2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define R2E_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/r2e_pkg.sv =====
// shared types, constants and the arctangent table of the euler angle core
// no dependencies
package r2e_pkg;

  localparam int DataW       = 16;
  localparam int LaneW       = 48;
  localparam int AngW        = 35;
  localparam int SqW         = 60;
  localparam int SqrtSteps   = 30;
  localparam int CordicSteps = 16;
  localparam int ThrW        = 15;
  localparam int PoleW       = 2;

  localparam logic [PoleW-1:0] PoleRegular = 2'd0;
  localparam logic [PoleW-1:0] PoleNorth   = 2'd1;
  localparam logic [PoleW-1:0] PoleSouth   = 2'd2;

  localparam logic [ThrW-1:0]        ThrReset = 15'd16351;
  localparam logic signed [AngW-1:0] PiAng    = 35'sd3373259426;
  localparam logic signed [15:0]     AngLim   = 16'sd25736;
  localparam logic signed [14:0]     PitchLim = 15'sd12868;
  localparam logic [5:0]             SqrtTop  = 6'd58;

  typedef struct packed {
    logic signed [LaneW-1:0] x;
    logic signed [LaneW-1:0] y;
  } vec_t;

  typedef struct packed {
    logic             valid;
    logic [PoleW-1:0] pole;
    vec_t             roll;
    vec_t             yaw;
    logic signed [DataW-1:0] s;
    logic [SqW-1:0]   v;
    logic [SqW-1:0]   r;
  } sqrt_word_t;

  typedef struct packed {
    logic signed [LaneW-1:0] x;
    logic signed [LaneW-1:0] y;
    logic signed [AngW-1:0]  z;
    logic                    zero;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [PoleW-1:0] pole;
    lane_t            roll;
    lane_t            pitch;
    lane_t            yaw;
  } cordic_word_t;

  typedef struct packed {
    logic [PoleW-1:0]  pole;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } out_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [AngW-1:0] atan_rom(logic [3:0] i);
    logic signed [AngW-1:0] a;
    case (i)
      4'd0:    a = 35'sd843314857;
      4'd1:    a = 35'sd497837829;
      4'd2:    a = 35'sd263043837;
      4'd3:    a = 35'sd133525159;
      4'd4:    a = 35'sd67021688;
      4'd5:    a = 35'sd33543516;
      4'd6:    a = 35'sd16775851;
      4'd7:    a = 35'sd8388437;
      4'd8:    a = 35'sd4194283;
      4'd9:    a = 35'sd2097149;
      4'd10:   a = 35'sd1048576;
      4'd11:   a = 35'sd524288;
      4'd12:   a = 35'sd262144;
      4'd13:   a = 35'sd131072;
      4'd14:   a = 35'sd65536;
      default: a = 35'sd32768;
    endcase
    return a;
  endfunction

  // fold the left half plane onto the right one
  function automatic lane_t lane_init(vec_t v);
    lane_t l;
    l.zero = (v.x == '0) && (v.y == '0);
    l.x    = v.x;
    l.y    = v.y;
    l.z    = '0;
    if (v.x < 0) begin
      l.z = (v.y >= 0) ? PiAng : -PiAng;
      l.x = -v.x;
      l.y = -v.y;
    end
    return l;
  endfunction

endpackage

// ===== rtl/core/r2e_sqrt_cell.sv =====
// one digit step of the integer square root chain
// depends on r2e_pkg
module r2e_sqrt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [4:0]          step_i,
  input  r2e_pkg::sqrt_word_t word_i,
  output r2e_pkg::sqrt_word_t word_o
);
  import r2e_pkg::*;

  logic [SqW-1:0] bit_w;
  logic [SqW-1:0] trial;
  sqrt_word_t     word_d;
  sqrt_word_t     pay_q;
  logic           valid_q;

  always_comb begin
    bit_w  = SqW'(1) << (SqrtTop - {step_i, 1'b0});
    trial  = word_i.r + bit_w;
    word_d = word_i;
    if (word_i.v >= trial) begin
      word_d.v = word_i.v - trial;
      word_d.r = (word_i.r >> 1) + bit_w;
    end else begin
      word_d.r = word_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= word_d;
    end
  end

  always_comb begin
    word_o       = pay_q;
    word_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/r2e_cordic_cell.sv =====
// one vectoring micro-rotation for the three angle lanes
// depends on r2e_pkg
module r2e_cordic_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [3:0]            step_i,
  input  r2e_pkg::cordic_word_t word_i,
  output r2e_pkg::cordic_word_t word_o
);
  import r2e_pkg::*;

  cordic_word_t word_d;
  cordic_word_t pay_q;
  logic         valid_q;

  function automatic lane_t rotate(lane_t l, logic [3:0] k);
    lane_t                   n;
    logic signed [LaneW-1:0] dx;
    logic signed [LaneW-1:0] dy;
    n  = l;
    dx = l.y >>> k;
    dy = l.x >>> k;
    if (l.y >= 0) begin
      n.x = l.x + dx;
      n.y = l.y - dy;
      n.z = l.z + atan_rom(k);
    end else begin
      n.x = l.x - dx;
      n.y = l.y + dy;
      n.z = l.z - atan_rom(k);
    end
    return n;
  endfunction

  always_comb begin
    word_d       = word_i;
    word_d.roll  = rotate(word_i.roll, step_i);
    word_d.pitch = rotate(word_i.pitch, step_i);
    word_d.yaw   = rotate(word_i.yaw, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= word_d;
    end
  end

  always_comb begin
    word_o       = pay_q;
    word_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/rotation_to_euler_angles_core.sv =====
// rotation matrix to euler angles, top level
// depends on r2e_pkg, r2e_sqrt_cell, r2e_cordic_cell and assert_macros.svh
//
// input channel s_axis: one word holds seven q2.14 matrix elements
// output m_axis: roll, yaw q3.13, pitch q2.13 radians, pole case in tuser
// cfg_we_i / cfg_wdata_i write the pole threshold; the user must do so only
//   while the core is idle, which the core itself does not enforce
// throughput: one word per cycle while s_axis_tready is high, set by the 30
//   square root cells and the 16 cordic cells that all advance together
// a two-entry output stage (output register plus skid) lets the core take
//   input while a result waits; once the skid entry fills, s_axis_tready
//   drops and the whole chain holds until m_axis_tready returns
// reset clears all valid bits and loads threshold 16351; no clearing pass
// pole cases give roll 0 and pitch of plus or minus pi/2
`include "assert_macros.svh"
module rotation_to_euler_angles_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // r00, r02, r10, r11, r12, r20, r22
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll, pitch, yaw, one zero pad bit
  output logic [47:0]  m_axis_tdata,
  // pole_case
  output logic [1:0]   m_axis_tuser
);
  import r2e_pkg::*;

  logic [ThrW-1:0] thr_q;
  logic            en;
  logic            accept;

  logic signed [DataW-1:0] r00, r02, r10, r11, r12, r20, r22;
  logic signed [16:0]      r10_x;
  logic signed [16:0]      thr_s;
  logic [PoleW-1:0]        pole_d;

  logic                    s0_v_q;
  logic [PoleW-1:0]        s0_pole_q;
  vec_t                    s0_roll_q;
  vec_t                    s0_yaw_q;
  logic signed [DataW-1:0] s0_s_q;
  logic signed [31:0]      s0_sq_q;
  logic signed [31:0]      s0_d;

  sqrt_word_t   sq_chain [SqrtSteps+1];
  cordic_word_t co_chain [CordicSteps+1];
  cordic_word_t prep_d;
  cordic_word_t prep_q;
  logic         prep_v_q;
  vec_t         pitch_vec;

  out_t fmt;
  out_t out_q;
  out_t skid_q;
  logic out_v_q;
  logic skid_v_q;

  function automatic logic signed [LaneW-1:0] scale(logic signed [DataW-1:0] a, logic neg);
    logic signed [LaneW-1:0] t;
    t = LaneW'(a);
    if (neg) begin
      t = -t;
    end
    return t <<< 30;
  endfunction

  function automatic logic signed [15:0] to_out(lane_t l, logic signed [15:0] lim);
    logic signed [AngW-1:0] z;
    logic signed [AngW-1:0] t;
    logic signed [17:0]     r;
    z = l.zero ? '0 : l.z;
    t = z + AngW'(65536);
    r = 18'(t >>> 17);
    if (r > 18'(lim)) begin
      r = 18'(lim);
    end else if (r < -18'(lim)) begin
      r = -18'(lim);
    end
    return r[15:0];
  endfunction

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  assign r00 = s_axis_tdata[15:0];
  assign r02 = s_axis_tdata[31:16];
  assign r10 = s_axis_tdata[47:32];
  assign r11 = s_axis_tdata[63:48];
  assign r12 = s_axis_tdata[79:64];
  assign r20 = s_axis_tdata[95:80];
  assign r22 = s_axis_tdata[111:96];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    r10_x = 17'(r10);
    thr_s = {2'b00, thr_q};
    if (r10_x > thr_s) begin
      pole_d = PoleNorth;
    end else if (r10_x < -thr_s) begin
      pole_d = PoleSouth;
    end else begin
      pole_d = PoleRegular;
    end
  end

  // input stage with the squaring multiplier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_pole_q   <= pole_d;
      s0_roll_q.y <= scale(r12, 1'b1);
      s0_roll_q.x <= scale(r11, 1'b0);
      if (pole_d != PoleRegular) begin
        s0_yaw_q.y <= scale(r02, 1'b0);
        s0_yaw_q.x <= scale(r22, 1'b0);
      end else begin
        s0_yaw_q.y <= scale(r20, 1'b1);
        s0_yaw_q.x <= scale(r00, 1'b0);
      end
      s0_s_q  <= r10;
      s0_sq_q <= r10 * r10;
    end
  end

  // radicand (1 - s^2) scaled by 2^58, clamped at zero
  always_comb begin
    s0_d             = 32'sd268435456 - s0_sq_q;
    sq_chain[0]       = '0;
    sq_chain[0].valid = s0_v_q;
    sq_chain[0].pole  = s0_pole_q;
    sq_chain[0].roll  = s0_roll_q;
    sq_chain[0].yaw   = s0_yaw_q;
    sq_chain[0].s     = s0_s_q;
    sq_chain[0].v     = s0_d[31] ? '0 : (SqW'(s0_d[28:0]) << 30);
  end

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    r2e_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (5'(g)),
      .word_i (sq_chain[g]),
      .word_o (sq_chain[g+1])
    );
  end

  // quadrant fold ahead of the cordic cells
  always_comb begin
    pitch_vec.y  = LaneW'(sq_chain[SqrtSteps].s) <<< 15;
    pitch_vec.x  = {{(LaneW-30){1'b0}}, sq_chain[SqrtSteps].r[29:0]};
    prep_d.valid = sq_chain[SqrtSteps].valid;
    prep_d.pole  = sq_chain[SqrtSteps].pole;
    prep_d.roll  = lane_init(sq_chain[SqrtSteps].roll);
    prep_d.pitch = lane_init(pitch_vec);
    prep_d.yaw   = lane_init(sq_chain[SqrtSteps].yaw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= prep_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  always_comb begin
    co_chain[0]       = prep_q;
    co_chain[0].valid = prep_v_q;
  end

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    r2e_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (4'(g)),
      .word_i (co_chain[g]),
      .word_o (co_chain[g+1])
    );
  end

  always_comb begin
    fmt.pole = co_chain[CordicSteps].pole;
    fmt.yaw  = to_out(co_chain[CordicSteps].yaw, AngLim);
    if (co_chain[CordicSteps].pole == PoleRegular) begin
      fmt.roll  = to_out(co_chain[CordicSteps].roll, AngLim);
      fmt.pitch = 15'(to_out(co_chain[CordicSteps].pitch, 16'(PitchLim)));
    end else begin
      fmt.roll  = '0;
      fmt.pitch = (co_chain[CordicSteps].pole == PoleNorth) ? PitchLim : -PitchLim;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (m_axis_tready) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= co_chain[CordicSteps].valid;
    end else if (co_chain[CordicSteps].valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_v_q || m_axis_tready) begin
      out_q <= fmt;
    end else begin
      skid_q <= fmt;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, out_q.yaw, out_q.pitch, out_q.roll};
  assign m_axis_tuser  = out_q.pole;

  `R2E_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid word held with empty output")
  `R2E_ASSERT(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready), "skid filled without stall")
  `R2E_ASSERT(a_north_fixed, out_v_q && out_q.pole == PoleNorth |-> out_q.pitch == PitchLim && out_q.roll == 0, "north pole word with wrong roll or pitch")
  `R2E_ASSERT(a_south_fixed, out_v_q && out_q.pole == PoleSouth |-> out_q.pitch == -PitchLim && out_q.roll == 0, "south pole word with wrong roll or pitch")

endmodule
